### rtl/core/pdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_pkg
// Widths, register indexes and controller/datapath interface types for the
// PD line-follow drive mixer.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int ERROR_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int GAIN_BITS  = 12;
    localparam int SPEED_BITS = 8;
    localparam int FRAC_BITS  = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = GAIN_BITS;

    localparam int DIFF_BITS  = ERROR_BITS + 1;
    localparam int NUM_BITS   = GAIN_BITS + 1 + DIFF_BITS;
    localparam int MAG_BITS   = GAIN_BITS + DIFF_BITS;
    localparam int P_BITS     = GAIN_BITS + 1 + ERROR_BITS;
    localparam int SUM_BITS   = MAG_BITS + 2;
    localparam int CORR_BITS  = SUM_BITS - FRAC_BITS;
    localparam int PROD_BITS  = CORR_BITS + GAIN_BITS + 1;
    localparam int WHEEL_BITS = PROD_BITS + 1;
    localparam int SPD_BITS   = WHEEL_BITS - FRAC_BITS;
    localparam int CNT_BITS   = $clog2(MAG_BITS + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_SPEED = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KP         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KD         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIX_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PWM_LIMIT  = 3'd4;

    localparam logic [SPEED_BITS-1:0] RST_BASE_SPEED = 8'd150;
    localparam logic [GAIN_BITS-1:0]  RST_KP         = 12'd51;
    localparam logic [GAIN_BITS-1:0]  RST_KD         = 12'd77;
    localparam logic [GAIN_BITS-1:0]  RST_MIX_GAIN   = 12'd166;
    localparam logic [SPEED_BITS-1:0] RST_PWM_LIMIT  = 8'd90;
    localparam logic [TIME_BITS-1:0]  RST_PREV_TIME  = TIME_BITS'(1);

    typedef struct packed {
        logic load;
        logic mul_d;
        logic div_step;
        logic prop;
        logic corr;
        logic mix;
        logic speed;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic div_last;
    } t_stat;

endpackage

### rtl/core/pdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_ctrl
// Sequencer: steps the datapath through multiply, serial divide, mix and
// clamp, and owns both handshakes.
// ----------------------------------------------------------------------------
module pdm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  pdm_pkg::t_stat i_stat,
    output pdm_pkg::t_cmd  o_cmd
);
    import pdm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MULD  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_PROP  = 8'b0000_1000,
        S_CORR  = 8'b0001_0000,
        S_MIX   = 8'b0010_0000,
        S_SPEED = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULD;
                end
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = i_stat.skip ? S_PROP : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_PROP;
                end
            end
            S_PROP: begin
                o_cmd.prop = 1'b1;
                n_state    = S_CORR;
            end
            S_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_SPEED;
            end
            S_SPEED: begin
                o_cmd.speed = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/pdm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_dp
// Datapath: gain registers, sample history, derivative multiply, restoring
// divider, correction mix and wheel clamp, output word registers.
// ----------------------------------------------------------------------------
module pdm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pdm_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [pdm_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic signed [pdm_pkg::ERROR_BITS-1:0] i_deviation,
    input  logic [pdm_pkg::TIME_BITS-1:0]        i_timestamp_us,
    input  pdm_pkg::t_cmd                        i_cmd,
    output pdm_pkg::t_stat                       o_stat,
    output logic                                 o_left_forward,
    output logic [pdm_pkg::SPEED_BITS-1:0]       o_left_pwm,
    output logic                                 o_right_forward,
    output logic [pdm_pkg::SPEED_BITS-1:0]       o_right_pwm,
    output logic                                 o_derivative_skipped
);
    import pdm_pkg::*;

    logic [SPEED_BITS-1:0] r_base, r_limit;
    logic [GAIN_BITS-1:0]  r_kp, r_kd, r_mix;

    logic signed [ERROR_BITS-1:0] r_prev_err, r_err;
    logic [TIME_BITS-1:0]         r_prev_time, r_elapsed;
    logic signed [DIFF_BITS-1:0]  r_diff;

    logic                  r_neg;
    logic [MAG_BITS-1:0]   r_quo;
    logic [TIME_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]   r_cnt;

    logic signed [P_BITS-1:0]    r_p;
    logic signed [CORR_BITS-1:0] r_corr;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [SPD_BITS-1:0]  r_left, r_right;

    logic signed [NUM_BITS-1:0]   w_num, w_num_abs;
    logic [TIME_BITS:0]           w_trial;
    logic                         w_ge;
    logic [TIME_BITS:0]           w_trial_sub;
    logic signed [MAG_BITS:0]     w_q, w_d;
    logic signed [SUM_BITS-1:0]   w_sum, w_sum_b;
    logic signed [WHEEL_BITS-1:0] w_base, w_prod, w_l, w_r, w_l_b, w_r_b;
    logic [SPD_BITS-1:0]          w_lmag, w_rmag;
    logic [SPD_BITS-1:0]          w_limit;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE_SPEED;
            r_kp    <= RST_KP;
            r_kd    <= RST_KD;
            r_mix   <= RST_MIX_GAIN;
            r_limit <= RST_PWM_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_SPEED: r_base  <= i_cfg_data[SPEED_BITS-1:0];
                CFG_KP:         r_kp    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_KD:         r_kd    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_MIX_GAIN:   r_mix   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_PWM_LIMIT:  r_limit <= i_cfg_data[SPEED_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sample history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_prev_time <= RST_PREV_TIME;
        end else if (i_cmd.load) begin
            r_prev_err  <= i_deviation;
            r_prev_time <= i_timestamp_us;
        end
    end

    assign w_num     = $signed({1'b0, r_kd}) * r_diff;
    assign w_num_abs = w_num[NUM_BITS-1] ? -w_num : w_num;

    assign w_trial     = {r_rem, r_quo[MAG_BITS-1]};
    assign w_ge        = (w_trial >= {1'b0, r_elapsed});
    assign w_trial_sub = w_trial - {1'b0, r_elapsed};

    assign w_q     = $signed({1'b0, r_quo});
    assign w_d     = o_stat.skip ? '0 : (r_neg ? -w_q : w_q);
    assign w_sum   = SUM_BITS'(w_d) + SUM_BITS'(r_p);
    // bias negatives so the shift truncates toward zero
    assign w_sum_b = w_sum + $signed({{(SUM_BITS-FRAC_BITS){1'b0}},
                                      {FRAC_BITS{w_sum[SUM_BITS-1]}}});

    assign w_base = $signed(WHEEL_BITS'({r_base, {FRAC_BITS{1'b0}}}));
    assign w_prod = WHEEL_BITS'(r_prod);
    assign w_l    = w_base - w_prod;
    assign w_r    = w_base + w_prod;
    assign w_l_b  = w_l + $signed({{(WHEEL_BITS-FRAC_BITS){1'b0}},
                                   {FRAC_BITS{w_l[WHEEL_BITS-1]}}});
    assign w_r_b  = w_r + $signed({{(WHEEL_BITS-FRAC_BITS){1'b0}},
                                   {FRAC_BITS{w_r[WHEEL_BITS-1]}}});

    assign w_lmag  = r_left[SPD_BITS-1]  ? SPD_BITS'(-r_left)  : SPD_BITS'(r_left);
    assign w_rmag  = r_right[SPD_BITS-1] ? SPD_BITS'(-r_right) : SPD_BITS'(r_right);
    assign w_limit = SPD_BITS'(r_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err     <= i_deviation;
            r_diff    <= $signed({i_deviation[ERROR_BITS-1], i_deviation})
                       - $signed({r_prev_err[ERROR_BITS-1], r_prev_err});
            r_elapsed <= i_timestamp_us - r_prev_time;
        end
        if (i_cmd.mul_d) begin
            r_neg <= w_num[NUM_BITS-1];
            r_quo <= w_num_abs[MAG_BITS-1:0];
            r_rem <= '0;
            r_cnt <= CNT_BITS'(MAG_BITS);
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial_sub[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
            r_quo <= {r_quo[MAG_BITS-2:0], w_ge};
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
        if (i_cmd.prop) begin
            r_p <= $signed({1'b0, r_kp}) * r_err;
        end
        if (i_cmd.corr) begin
            r_corr <= w_sum_b[SUM_BITS-1:FRAC_BITS];
        end
        if (i_cmd.mix) begin
            r_prod <= r_corr * $signed({1'b0, r_mix});
        end
        if (i_cmd.speed) begin
            r_left  <= w_l_b[WHEEL_BITS-1:FRAC_BITS];
            r_right <= w_r_b[WHEEL_BITS-1:FRAC_BITS];
        end
        if (i_cmd.out_load) begin
            o_left_forward       <= !r_left[SPD_BITS-1];
            o_left_pwm           <= (w_lmag > w_limit) ? r_limit : w_lmag[SPEED_BITS-1:0];
            o_right_forward      <= !r_right[SPD_BITS-1];
            o_right_pwm          <= (w_rmag > w_limit) ? r_limit : w_rmag[SPEED_BITS-1:0];
            o_derivative_skipped <= o_stat.skip;
        end
    end

    assign o_stat.skip     = (r_elapsed == '0);
    assign o_stat.div_last = (r_cnt == CNT_BITS'(1));

endmodule

### rtl/core/pd_line_follow_drive_mixer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_line_follow_drive_mixer_top
// PD line-follow controller with differential drive mixing.
// ----------------------------------------------------------------------------
// Input channel: one word per sample, deviation and timestamp_us, taken when
// i_in_valid is high and o_in_stall is low. Output channel: one word per
// sample, wheel directions, PWM values and the derivative-skipped flag,
// taken when o_out_valid is high and i_out_stall is low.
// Config: gains, base speed and PWM limit are written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must do so only while the block is
// idle, which the block itself does not enforce; unknown indexes are ignored.
// The bit-serial restoring divider produces one quotient bit per cycle; the
// divide is skipped when the elapsed time is zero. A new input is accepted
// only after the previous word has been loaded into the output register.
// A finished word sits in the output register; a new input is accepted while
// the receiver stalls, and the block waits before its final step only if the
// previous word is still untaken.
// Reset clears the handshakes, restores the default gains and sets the
// previous sample to deviation 0 at time 1.
// ----------------------------------------------------------------------------
module pd_line_follow_drive_mixer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pdm_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [pdm_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [pdm_pkg::ERROR_BITS-1:0] i_deviation,
    input  logic [pdm_pkg::TIME_BITS-1:0]         i_timestamp_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_left_forward,
    output logic [pdm_pkg::SPEED_BITS-1:0]        o_left_pwm,
    output logic                                  o_right_forward,
    output logic [pdm_pkg::SPEED_BITS-1:0]        o_right_pwm,
    output logic                                  o_derivative_skipped
);
    import pdm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pdm_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_deviation          (i_deviation),
        .i_timestamp_us       (i_timestamp_us),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .o_left_forward       (o_left_forward),
        .o_left_pwm           (o_left_pwm),
        .o_right_forward      (o_right_forward),
        .o_right_pwm          (o_right_pwm),
        .o_derivative_skipped (o_derivative_skipped)
    );

endmodule
